// ===== rtl/bmt_pkg.sv =====
// ============================================================================
// bmt_pkg - shared types and constants for the breakpoint match table
// opcodes, status codes, cell commands and the words passed along the chain
// ============================================================================
package bmt_pkg;

    // fixed field widths of the command and result words
    localparam int OP_W       = 3;
    localparam int ADDR_W     = 16;
    localparam int IN_IDX_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 3;
    localparam int HITS_W     = 16;
    localparam int ENTRIES_W  = 4;

    // slot number carried along the chain, wide enough for tables of up to 64 entries
    localparam int CHAIN_SLOT_W = 6;

    // parameter defaults
    localparam int DEF_ENTRIES   = 8;
    localparam int DEF_ADDR_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_CHECK   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_IDX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_WRITE,
        CELL_SHIFT,
        CELL_SET_EN,
        CELL_CLR_EN,
        CELL_COMPARE,
        CELL_BUMP
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_HIT
    } fsm_t;

    // command broadcast to every cell
    typedef struct packed {
        cell_op_t            op;
        logic [ADDR_W-1:0]   addr;
    } cell_cmd_t;

    // entry contents handed from a cell to its lower neighbor on remove
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic                en;
        logic [HITS_W-1:0]   hits;
    } entry_t;

    // priority chain for check: first enabled match wins
    typedef struct packed {
        logic                    found;
        logic [CHAIN_SLOT_W-1:0] slot;
        logic [HITS_W-1:0]       hits;
    } match_chain_t;

endpackage

// ===== rtl/bmt_cell.sv =====
// ============================================================================
// bmt_cell - one breakpoint table entry
// holds address, enable and hit counter; shifts from its upper neighbor on
// remove and takes part in the first-match priority chain on check
// ============================================================================
module bmt_cell #(
    parameter int ENTRIES   = bmt_pkg::DEF_ENTRIES,
    parameter int ADDR_BITS = bmt_pkg::DEF_ADDR_BITS,
    parameter int INDEX     = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bmt_pkg::cell_cmd_t            cmd,
    input  logic [$clog2(ENTRIES+1)-1:0]  sel_idx,
    input  logic [$clog2(ENTRIES+1)-1:0]  count,
    input  bmt_pkg::entry_t               nbr_in,
    output bmt_pkg::entry_t               nbr_out,
    input  bmt_pkg::match_chain_t         chain_in,
    output bmt_pkg::match_chain_t         chain_out
);

    localparam int CNT_W = $clog2(ENTRIES+1);
    localparam int AW    = (ADDR_BITS < bmt_pkg::ADDR_W) ? ADDR_BITS : bmt_pkg::ADDR_W;
    localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

    logic [AW-1:0]                 addr_reg;
    logic                          en_reg;
    logic                          en_next;
    logic [bmt_pkg::HITS_W-1:0]    hits_reg;
    logic [bmt_pkg::HITS_W-1:0]    hits_next;
    logic [bmt_pkg::HITS_W-1:0]    hits_inc;
    logic                          match_reg;
    logic                          match_next;
    logic                          live;
    logic                          win;

    assign live     = POS < count;
    assign win      = match_reg & ~chain_in.found;
    assign hits_inc = (hits_reg == {bmt_pkg::HITS_W{1'b1}}) ? hits_reg : hits_reg + 1'b1;

    always_comb
    begin
        en_next    = en_reg;
        hits_next  = hits_reg;
        match_next = match_reg;
        unique case (cmd.op)
            bmt_pkg::CELL_WRITE:
            begin
                if (POS == count)
                begin
                    en_next   = 1'b1;
                    hits_next = '0;
                end
            end
            bmt_pkg::CELL_SHIFT:
            begin
                if (POS >= sel_idx)
                begin
                    en_next   = nbr_in.en;
                    hits_next = nbr_in.hits;
                end
            end
            bmt_pkg::CELL_SET_EN:
            begin
                if (POS == sel_idx)
                    en_next = 1'b1;
            end
            bmt_pkg::CELL_CLR_EN:
            begin
                if (POS == sel_idx)
                    en_next = 1'b0;
            end
            bmt_pkg::CELL_COMPARE:
            begin
                match_next = live & en_reg & (addr_reg == cmd.addr[AW-1:0]);
            end
            bmt_pkg::CELL_BUMP:
            begin
                if (win)
                    hits_next = hits_inc;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            hits_reg  <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            en_reg    <= en_next;
            hits_reg  <= hits_next;
            match_reg <= match_next;
        end
    end

    // address store, meaningful once written by add
    always_ff @(posedge clk)
    begin
        if (cmd.op == bmt_pkg::CELL_WRITE && POS == count)
            addr_reg <= cmd.addr[AW-1:0];
        else if (cmd.op == bmt_pkg::CELL_SHIFT && POS >= sel_idx)
            addr_reg <= nbr_in.addr[AW-1:0];
    end

    assign nbr_out.addr = bmt_pkg::ADDR_W'(addr_reg);
    assign nbr_out.en   = en_reg;
    assign nbr_out.hits = hits_reg;

    assign chain_out.found = chain_in.found | match_reg;
    assign chain_out.slot  = chain_in.slot
                           | (win ? bmt_pkg::CHAIN_SLOT_W'(INDEX) : '0);
    assign chain_out.hits  = chain_in.hits | (win ? hits_inc : '0);

endmodule

// ===== rtl/breakpoint_match_table.sv =====
// ============================================================================
// breakpoint_match_table - ordered table of hardware breakpoints
// add, remove, enable, disable and check against a compacted entry table
// ============================================================================
// A command word is taken when start is high and busy is low. Add, remove,
// enable, disable and unknown opcodes complete in the idle state. Check
// compares in every cell in the idle state; in the hit state, busy is high
// and the first enabled match along the cell chain has its counter bumped.
// Each result word appears on status, slot, hit, hit_tally and entries for
// exactly one cycle with done high, the cycle after the command finishes.
// The receiver cannot stall: a result must be captured in its done cycle.
// A new command may be issued in the same cycle that done is high.
// ============================================================================
module breakpoint_match_table #(
    parameter int ENTRIES   = bmt_pkg::DEF_ENTRIES,
    parameter int ADDR_BITS = bmt_pkg::DEF_ADDR_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bmt_pkg::OP_W-1:0]        opcode,
    input  logic [bmt_pkg::ADDR_W-1:0]      address,
    input  logic [bmt_pkg::IN_IDX_W-1:0]    slot_index,
    output logic                            done,
    output logic [bmt_pkg::STATUS_W-1:0]    status,
    output logic [bmt_pkg::SLOT_W-1:0]      slot,
    output logic                            hit,
    output logic [bmt_pkg::HITS_W-1:0]      hit_tally,
    output logic [bmt_pkg::ENTRIES_W-1:0]   entries
);

    localparam int CNT_W = $clog2(ENTRIES+1);
    // compare width for slot_index against the entry count
    localparam int CMP_W = (CNT_W > bmt_pkg::IN_IDX_W) ? CNT_W : bmt_pkg::IN_IDX_W;

    bmt_pkg::fsm_t                  state_reg;
    bmt_pkg::fsm_t                  state_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;

    logic                           done_reg;
    logic                           done_next;
    logic [bmt_pkg::STATUS_W-1:0]   status_reg;
    logic [bmt_pkg::STATUS_W-1:0]   status_next;
    logic [bmt_pkg::SLOT_W-1:0]     slot_reg;
    logic [bmt_pkg::SLOT_W-1:0]     slot_next;
    logic                           hit_reg;
    logic                           hit_next;
    logic [bmt_pkg::HITS_W-1:0]     hit_tally_reg;
    logic [bmt_pkg::HITS_W-1:0]     hit_tally_next;
    logic [bmt_pkg::ENTRIES_W-1:0]  entries_reg;

    bmt_pkg::cell_cmd_t             cmd;
    logic                           accept;
    logic                           idx_ok;
    logic                           full;

    // neighbor data and match chain between the cells
    bmt_pkg::entry_t                nbr   [ENTRIES+1];
    bmt_pkg::match_chain_t          chain [ENTRIES+1];

    assign accept = start & (state_reg == bmt_pkg::FSM_IDLE);
    assign idx_ok = CMP_W'(slot_index) < CMP_W'(count_reg);
    assign full   = count_reg == CNT_W'(ENTRIES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmt_pkg::FSM_IDLE:
            begin
                if (accept && opcode == bmt_pkg::OP_CHECK)
                    state_next = bmt_pkg::FSM_HIT;
            end
            bmt_pkg::FSM_HIT:
            begin
                state_next = bmt_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = bmt_pkg::FSM_IDLE;
            end
        endcase
    end

    // cell commands, entry count and result word
    always_comb
    begin
        cmd.op         = bmt_pkg::CELL_NOP;
        cmd.addr       = address;
        count_next     = count_reg;
        done_next      = 1'b0;
        status_next    = bmt_pkg::ST_OK;
        slot_next      = '0;
        hit_next       = 1'b0;
        hit_tally_next = '0;
        unique case (state_reg)
            bmt_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    unique case (opcode)
                        bmt_pkg::OP_ADD:
                        begin
                            if (full)
                                status_next = bmt_pkg::ST_FULL;
                            else
                            begin
                                cmd.op     = bmt_pkg::CELL_WRITE;
                                slot_next  = bmt_pkg::SLOT_W'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bmt_pkg::OP_REMOVE:
                        begin
                            if (!idx_ok)
                                status_next = bmt_pkg::ST_BAD_IDX;
                            else
                            begin
                                cmd.op     = bmt_pkg::CELL_SHIFT;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bmt_pkg::OP_ENABLE:
                        begin
                            if (!idx_ok)
                                status_next = bmt_pkg::ST_BAD_IDX;
                            else
                                cmd.op = bmt_pkg::CELL_SET_EN;
                        end
                        bmt_pkg::OP_DISABLE:
                        begin
                            if (!idx_ok)
                                status_next = bmt_pkg::ST_BAD_IDX;
                            else
                                cmd.op = bmt_pkg::CELL_CLR_EN;
                        end
                        bmt_pkg::OP_CHECK:
                        begin
                            // result comes out of the hit cycle
                            cmd.op    = bmt_pkg::CELL_COMPARE;
                            done_next = 1'b0;
                        end
                        default:
                        begin
                            // unknown opcode: nothing changes
                        end
                    endcase
                end
            end
            bmt_pkg::FSM_HIT:
            begin
                // first enabled match resolved along the chain, counter bumped
                cmd.op         = bmt_pkg::CELL_BUMP;
                done_next      = 1'b1;
                hit_next       = chain[ENTRIES].found;
                slot_next      = bmt_pkg::SLOT_W'(chain[ENTRIES].slot);
                hit_tally_next = chain[ENTRIES].hits;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmt_pkg::FSM_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // result word, loaded when a command completes
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            hit_reg       <= hit_next;
            hit_tally_reg <= hit_tally_next;
            entries_reg   <= bmt_pkg::ENTRIES_W'(count_next);
        end
    end

    // chain ends: nothing above the top cell, no match before cell zero
    assign nbr[ENTRIES] = '0;
    assign chain[0]     = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bmt_cell #(
            .ENTRIES   (ENTRIES),
            .ADDR_BITS (ADDR_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel_idx   (CNT_W'(slot_index)),
            .count     (count_reg),
            .nbr_in    (nbr[i+1]),
            .nbr_out   (nbr[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    assign busy      = state_reg == bmt_pkg::FSM_HIT;
    assign done      = done_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign hit       = hit_reg;
    assign hit_tally = hit_tally_reg;
    assign entries   = entries_reg;

endmodule
